// ----- rtl/deq_pkg.sv -----
// Shared types and constants for the double-ended queue.
// Command and status codes, datapath operations, control/status bundles.
// No dependencies.
`timescale 1ns / 1ps

package deq_pkg;

  // Field widths of the channels
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned HELD_W  = 6;

  // Command codes on the input channel
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd4;

  // Status codes on the result channel
  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

  // Operation the datapath applies when a command is taken
  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_DUMP,
    OP_REJECT_FULL,
    OP_REPORT_EMPTY
  } deq_op_t;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_RESULT
  } deq_state_t;

  // Controller to datapath
  typedef struct packed {
    deq_op_t op;        // operation for the command taken this cycle
    logic    load_out;  // move pending result into the output register
    logic    dump_step; // read the next dump entry
  } deq_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic pend_last;    // pending result is the final one of its command
    logic out_free;     // output register empty or drained this cycle
  } deq_stat_t;

endpackage

// ----- rtl/deq_stream_if.sv -----
// Valid/ready channel interfaces for the queue's command and result streams.
// Depends on deq_pkg.
`timescale 1ns / 1ps

interface deq_in_if import deq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, command, value, input ready);
  modport sink   (input valid, command, value, output ready);
endinterface

interface deq_out_if import deq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic signed [DATA_W-1:0] value_out;
  logic [STAT_W-1:0]   status;
  logic [HELD_W-1:0]   entries_held;
  logic                last;

  modport source (output valid, value_out, status, entries_held, last, input ready);
  modport sink   (input valid, value_out, status, entries_held, last, output ready);
endinterface

// ----- rtl/double_ended_queue.sv -----
// Top level of the bounded double-ended queue of signed 32-bit words.
// Depends on deq_pkg, deq_stream_if, deq_ctrl, deq_datapath, deq_ram.
//
//   Channel   Direction  Fields                                  Transfer when
//   in_chan   in         command[2:0], value[31:0]               valid && ready
//   out_chan  out        value_out[31:0], status[1:0],
//                        entries_held[5:0], last                  valid && ready
//
// Every command but an unused code gives a result via the pending result registers;
// pops and dumps read the ring store through its registered read port.
// A dump streams one entry per cycle while the sink takes them.
// A new command is taken in the cycle the previous command's last result
// enters the output register, so with the sink ready one command per cycle outside dumps.
// Reset (rst_n low, synchronous) empties the queue; no clearing pass is run.
// A stalled sink holds the output register and, behind it, the controller.
`timescale 1ns / 1ps

module double_ended_queue import deq_pkg::*; #(
  parameter int unsigned DEPTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  deq_in_if.sink       in_chan,
  deq_out_if.source    out_chan
);

  deq_ctl_t  ctl;
  deq_stat_t stat;

  deq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_command (in_chan.command),
    .stat       (stat),
    .in_ready   (in_chan.ready),
    .ctl        (ctl)
  );

  deq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .push_value (in_chan.value),
    .out_ready  (out_chan.ready),
    .stat       (stat),
    .out_valid  (out_chan.valid),
    .out_value  (out_chan.value_out),
    .out_status (out_chan.status),
    .out_held   (out_chan.entries_held),
    .out_last   (out_chan.last)
  );

endmodule

// ----- rtl/deq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module deq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/deq_datapath.sv -----
// Queue datapath: ring pointers, entry count, ring store, dump walker,
// pending result and output register.
// Depends on deq_pkg and deq_ram.
`timescale 1ns / 1ps

module deq_datapath import deq_pkg::*; #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  deq_ctl_t                 ctl,
  input  logic [DATA_W-1:0]        push_value,
  input  logic                     out_ready,
  output deq_stat_t                stat,
  output logic                     out_valid,
  output logic [DATA_W-1:0]        out_value,
  output logic [STAT_W-1:0]        out_status,
  output logic [HELD_W-1:0]        out_held,
  output logic                     out_last
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  // Ring index helpers
  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] idx);
    idx_inc = (idx == IW'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] idx);
    idx_dec = (idx == '0) ? IW'(DEPTH - 1) : idx - 1'b1;
  endfunction

  // front plus an offset below DEPTH, wrapped once
  function automatic logic [IW-1:0] idx_add(input logic [IW-1:0] base,
                                            input logic [CW-1:0] offs);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(offs);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    idx_add = sum[IW-1:0];
  endfunction

  // Queue state
  logic [IW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // Dump walker
  logic [IW-1:0] walk_r, walk_nxt;
  logic [CW-1:0] remain_r, remain_nxt;

  // Pending result
  logic              pend_ram_r, pend_ram_nxt;
  logic [STAT_W-1:0] pend_status_r, pend_status_nxt;
  logic [CW-1:0]     pend_held_r, pend_held_nxt;
  logic              pend_last_r, pend_last_nxt;

  // Output register
  logic              out_valid_r;
  logic [DATA_W-1:0] out_value_r;
  logic [STAT_W-1:0] out_status_r;
  logic [HELD_W-1:0] out_held_r;
  logic              out_last_r;

  // Ring store ports
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;

  logic [CW-1:0]        count_m1;
  logic [CW+HELD_W-1:0] held_ext;

  assign count_m1 = count_r - 1'b1;
  assign held_ext = {{HELD_W{1'b0}}, pend_held_r};

  deq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (push_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Apply the operation of a taken command, or step the dump
  always_comb begin
    front_nxt       = front_r;
    count_nxt       = count_r;
    walk_nxt        = walk_r;
    remain_nxt      = remain_r;
    pend_ram_nxt    = pend_ram_r;
    pend_status_nxt = pend_status_r;
    pend_held_nxt   = pend_held_r;
    pend_last_nxt   = pend_last_r;
    wr_en           = 1'b0;
    wr_addr         = front_r;
    rd_en           = 1'b0;
    rd_addr         = front_r;

    if (ctl.dump_step) begin
      rd_en         = 1'b1;
      rd_addr       = walk_r;
      walk_nxt      = idx_inc(walk_r);
      remain_nxt    = remain_r - 1'b1;
      pend_last_nxt = (remain_r == CW'(1));
    end

    case (ctl.op)
      OP_PUSH_FRONT: begin
        wr_en           = 1'b1;
        wr_addr         = idx_dec(front_r);
        front_nxt       = idx_dec(front_r);
        count_nxt       = count_r + 1'b1;
        pend_ram_nxt    = 1'b0;
        pend_status_nxt = STATUS_OK;
        pend_held_nxt   = count_r + 1'b1;
        pend_last_nxt   = 1'b1;
      end
      OP_PUSH_BACK: begin
        wr_en           = 1'b1;
        wr_addr         = idx_add(front_r, count_r);
        count_nxt       = count_r + 1'b1;
        pend_ram_nxt    = 1'b0;
        pend_status_nxt = STATUS_OK;
        pend_held_nxt   = count_r + 1'b1;
        pend_last_nxt   = 1'b1;
      end
      OP_POP_FRONT: begin
        rd_en           = 1'b1;
        rd_addr         = front_r;
        front_nxt       = idx_inc(front_r);
        count_nxt       = count_m1;
        pend_ram_nxt    = 1'b1;
        pend_status_nxt = STATUS_OK;
        pend_held_nxt   = count_m1;
        pend_last_nxt   = 1'b1;
      end
      OP_POP_BACK: begin
        rd_en           = 1'b1;
        rd_addr         = idx_add(front_r, count_m1);
        count_nxt       = count_m1;
        pend_ram_nxt    = 1'b1;
        pend_status_nxt = STATUS_OK;
        pend_held_nxt   = count_m1;
        pend_last_nxt   = 1'b1;
      end
      OP_DUMP: begin
        rd_en           = 1'b1;
        rd_addr         = front_r;
        walk_nxt        = idx_inc(front_r);
        remain_nxt      = count_m1;
        pend_ram_nxt    = 1'b1;
        pend_status_nxt = STATUS_OK;
        pend_held_nxt   = count_r;
        pend_last_nxt   = (count_r == CW'(1));
      end
      OP_REJECT_FULL: begin
        pend_ram_nxt    = 1'b0;
        pend_status_nxt = STATUS_FULL;
        pend_held_nxt   = count_r;
        pend_last_nxt   = 1'b1;
      end
      OP_REPORT_EMPTY: begin
        pend_ram_nxt    = 1'b0;
        pend_status_nxt = STATUS_EMPTY;
        pend_held_nxt   = count_r;
        pend_last_nxt   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
      if (ctl.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    walk_r        <= walk_nxt;
    remain_r      <= remain_nxt;
    pend_ram_r    <= pend_ram_nxt;
    pend_status_r <= pend_status_nxt;
    pend_held_r   <= pend_held_nxt;
    pend_last_r   <= pend_last_nxt;
    if (ctl.load_out) begin
      out_value_r  <= pend_ram_r ? rd_data : '0;
      out_status_r <= pend_status_r;
      out_held_r   <= held_ext[HELD_W-1:0];
      out_last_r   <= pend_last_r;
    end
  end

  assign stat.empty     = (count_r == '0);
  assign stat.full      = (count_r == CW'(DEPTH));
  assign stat.pend_last = pend_last_r;
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;
  assign out_held   = out_held_r;
  assign out_last   = out_last_r;

endmodule

// ----- rtl/deq_ctrl.sv -----
// Queue controller: decodes commands and sequences result delivery.
// Depends on deq_pkg.
`timescale 1ns / 1ps

module deq_ctrl import deq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_command,
  input  deq_stat_t        stat,
  output logic             in_ready,
  output deq_ctl_t         ctl
);

  deq_state_t state_r, state_nxt;
  deq_op_t    dec_op;

  // Command to datapath operation, given the queue's fill level
  always_comb begin
    case (in_command)
      CMD_PUSH_FRONT: dec_op = stat.full  ? OP_REJECT_FULL  : OP_PUSH_FRONT;
      CMD_PUSH_BACK:  dec_op = stat.full  ? OP_REJECT_FULL  : OP_PUSH_BACK;
      CMD_POP_FRONT:  dec_op = stat.empty ? OP_REPORT_EMPTY : OP_POP_FRONT;
      CMD_POP_BACK:   dec_op = stat.empty ? OP_REPORT_EMPTY : OP_POP_BACK;
      CMD_DUMP:       dec_op = stat.empty ? OP_REPORT_EMPTY : OP_DUMP;
      default:        dec_op = OP_NONE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    ctl.op        = OP_NONE;
    ctl.load_out  = 1'b0;
    ctl.dump_step = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.op = dec_op;
          if (dec_op != OP_NONE) begin
            state_nxt = ST_RESULT;
          end
        end
      end
      ST_RESULT: begin
        if (stat.out_free) begin
          ctl.load_out = 1'b1;
          if (stat.pend_last) begin
            // final result leaves; the next command may enter alongside
            in_ready  = 1'b1;
            state_nxt = ST_IDLE;
            if (in_valid) begin
              ctl.op = dec_op;
              if (dec_op != OP_NONE) begin
                state_nxt = ST_RESULT;
              end
            end
          end else begin
            ctl.dump_step = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
